[design/cdns_pkg.sv]
// Shared types, constants and the answer-record table of the DNS responder core.
`default_nettype none
package cdns_pkg;

    // Sizes
    localparam int PACKET_BYTES_DEF = 512;
    localparam int ANSWER_BYTES     = 16;
    localparam int REC_IDX_W        = $clog2(ANSWER_BYTES);
    localparam int HEADER_BYTES     = 12;
    localparam int POS_W            = 10;
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_IDX_W = $clog2(QUEUE_DEPTH);

    // Header rewrite values
    localparam logic [7:0] HDR_FLAGS_HI = 8'h81;
    localparam logic [7:0] HDR_FLAGS_LO = 8'h80;
    localparam logic [7:0] ANCOUNT_LO   = 8'h01;

    // Answer record bytes
    localparam logic [7:0] REC_PTR_HI = 8'hC0;
    localparam logic [7:0] REC_PTR_LO = 8'h0C;
    localparam logic [7:0] REC_ONE    = 8'h01;
    localparam logic [7:0] REC_TTL_LO = 8'h3C;
    localparam logic [7:0] REC_RDLEN  = 8'h04;

    // One queued reply byte plus what the back end must do after it
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       discard;
        logic       append;
    } cdns_entry_t;

    typedef enum logic {
        BK_PASS,
        BK_RECORD
    } back_state_t;

    // Byte idx of the appended A record
    function automatic logic [7:0] rec_byte(input logic [REC_IDX_W-1:0] idx,
                                            input logic [31:0] addr);
        logic [7:0] b;
        b = 8'h00;
        case (idx)
            4'd0:    b = REC_PTR_HI;
            4'd1:    b = REC_PTR_LO;
            4'd3:    b = REC_ONE;
            4'd5:    b = REC_ONE;
            4'd9:    b = REC_TTL_LO;
            4'd11:   b = REC_RDLEN;
            4'd12:   b = addr[31:24];
            4'd13:   b = addr[23:16];
            4'd14:   b = addr[15:8];
            4'd15:   b = addr[7:0];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

[design/cdns_front.sv]
// Front end: tracks query position, rewrites the header and classifies the end of each query.
`default_nettype none
module cdns_front
    import cdns_pkg::*;
#(
    parameter int PACKET_BYTES = PACKET_BYTES_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,
    input  wire logic        s_axis_tlast,
    input  wire logic        queue_full,
    output logic             push,
    output cdns_entry_t      push_entry
);

    localparam int MAX_QUERY = PACKET_BYTES - ANSWER_BYTES;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic             rejected_reg, rejected_next;
    logic             flag_bad;
    logic             reject_now;
    logic [POS_W:0]   len;
    logic             discard;
    logic [7:0]       ob;

    assign s_axis_tready = !queue_full;
    assign push          = s_axis_tvalid && s_axis_tready;

    // Header rewrite by position
    always_comb begin
        case (pos_reg)
            10'd2:                         ob = HDR_FLAGS_HI;
            10'd3:                         ob = HDR_FLAGS_LO;
            10'd7:                         ob = ANCOUNT_LO;
            10'd6, 10'd8, 10'd9, 10'd10,
            10'd11:                        ob = 8'h00;
            default:                       ob = s_axis_tdata;
        endcase
    end

    // QR set or nonzero opcode in the flags byte
    assign flag_bad   = (pos_reg == 10'd2) &&
                        (s_axis_tdata[7] || (s_axis_tdata[6:3] != 4'd0));
    assign reject_now = rejected_reg || flag_bad;
    assign len        = {1'b0, pos_reg} + (POS_W+1)'(1);
    assign discard    = reject_now || (len < (POS_W+1)'(HEADER_BYTES)) ||
                        (len > (POS_W+1)'(MAX_QUERY));

    // Entry for the queue
    always_comb begin
        push_entry.data    = ob;
        push_entry.last    = s_axis_tlast && discard;
        push_entry.discard = s_axis_tlast && discard;
        push_entry.append  = s_axis_tlast && !discard;
    end

    // Position and reject flag
    always_comb begin
        pos_next      = pos_reg;
        rejected_next = rejected_reg;
        if (push) begin
            if (s_axis_tlast) begin
                pos_next      = '0;
                rejected_next = 1'b0;
            end else begin
                pos_next      = (pos_reg == POS_MAX) ? pos_reg : pos_reg + POS_W'(1);
                rejected_next = reject_now;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            rejected_reg <= 1'b0;
        end else begin
            pos_reg      <= pos_next;
            rejected_reg <= rejected_next;
        end
    end

endmodule
`default_nettype wire

[design/cdns_queue.sv]
// Short queue of classified reply bytes between front and back.
`default_nettype none
module cdns_queue
    import cdns_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  push,
    input  cdns_entry_t push_entry,
    output logic       full,
    input  wire logic  pop,
    output cdns_entry_t pop_entry,
    output logic       not_empty
);

    cdns_entry_t              mem_reg [QUEUE_DEPTH];
    logic [QUEUE_IDX_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_IDX_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_IDX_W:0]     count_reg, count_next;

    assign full      = (count_reg == (QUEUE_IDX_W+1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_entry = mem_reg[rd_ptr_reg];

    // Pointer and count update
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + QUEUE_IDX_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QUEUE_IDX_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) count_next = count_reg + (QUEUE_IDX_W+1)'(1);
        if (!push && pop) count_next = count_reg - (QUEUE_IDX_W+1)'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= push_entry;
    end

endmodule
`default_nettype wire

[design/cdns_back.sv]
// Back end: drains the queue into the output register and appends the A record.
`default_nettype none
module cdns_back
    import cdns_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic [31:0] answer_addr,
    input  wire logic        q_not_empty,
    input  cdns_entry_t      q_entry,
    output logic             pop,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,
    output logic             m_axis_tlast,
    output logic             m_axis_tuser
);

    back_state_t            state_reg, state_next;
    logic [REC_IDX_W-1:0]   idx_reg, idx_next;
    logic                   valid_reg, valid_next;
    logic [7:0]             data_reg, data_next;
    logic                   last_reg, last_next;
    logic                   user_reg, user_next;
    logic                   load;
    logic                   rec_done;

    assign load     = !valid_reg || m_axis_tready;
    assign rec_done = (idx_reg == REC_IDX_W'(ANSWER_BYTES - 1));

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_PASS:   if (load && q_not_empty && q_entry.append) state_next = BK_RECORD;
            BK_RECORD: if (load && rec_done)                      state_next = BK_PASS;
            default:   state_next = BK_PASS;
        endcase
    end

    // Outputs and output register loads
    always_comb begin
        pop        = 1'b0;
        idx_next   = idx_reg;
        valid_next = valid_reg && !m_axis_tready;
        data_next  = data_reg;
        last_next  = last_reg;
        user_next  = user_reg;
        unique case (state_reg)
            BK_PASS: begin
                if (load && q_not_empty) begin
                    pop        = 1'b1;
                    valid_next = 1'b1;
                    data_next  = q_entry.data;
                    last_next  = q_entry.last;
                    user_next  = q_entry.discard;
                    idx_next   = '0;
                end
            end
            BK_RECORD: begin
                if (load) begin
                    valid_next = 1'b1;
                    data_next  = rec_byte(idx_reg, answer_addr);
                    last_next  = rec_done;
                    user_next  = 1'b0;
                    idx_next   = idx_reg + REC_IDX_W'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_PASS;
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    // Payload register
    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        last_reg <= last_next;
        user_reg <= user_next;
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = data_reg;
    assign m_axis_tlast  = last_reg;
    assign m_axis_tuser  = user_reg;

endmodule
`default_nettype wire

[design/captive_dns_responder_core.sv]
// Top level of the streaming captive-portal DNS responder.
//
// Channel   Dir  Payload
// s_axis    in   tdata[7:0] query byte, tlast end of query
// m_axis    out  tdata[7:0] reply byte, tlast end of reply, tuser discard
// cfg       in   cfg_wdata[31:0] answer address, written when cfg_we is high
//
// One query byte per cycle is accepted while the queue is not full and is echoed
// through the register-free front, the four-entry queue and the output register.
// An accepted query adds 16 record bytes at one per cycle while the output is ready;
// the input keeps flowing into the queue until it fills during those bytes.
// Reset is synchronous, active low; the answer address resets to zero.
// Either side may stall on its own; the queue absorbs up to four bytes.
`default_nettype none
module captive_dns_responder_core
    import cdns_pkg::*;
#(
    parameter int PACKET_BYTES = PACKET_BYTES_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata,       // answer_address
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,    // [7:0] query_byte
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,    // [7:0] reply_byte
    output logic             m_axis_tlast,
    output logic             m_axis_tuser     // [0] reply_discard
);

    logic [31:0]  answer_addr_reg;
    logic         push;
    cdns_entry_t  push_entry;
    logic         q_full;
    logic         pop;
    cdns_entry_t  q_entry;
    logic         q_not_empty;

    // Answer address register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            answer_addr_reg <= '0;
        end else if (cfg_we) begin
            answer_addr_reg <= cfg_wdata;
        end
    end

    cdns_front #(
        .PACKET_BYTES (PACKET_BYTES)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .queue_full    (q_full),
        .push          (push),
        .push_entry    (push_entry)
    );

    cdns_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .pop_entry  (q_entry),
        .not_empty  (q_not_empty)
    );

    cdns_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .answer_addr   (answer_addr_reg),
        .q_not_empty   (q_not_empty),
        .q_entry       (q_entry),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
`default_nettype wire

[design/cdns_checker.sv]
// Port-level checks of the DNS responder core and their bind.
`default_nettype none
module cdns_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        cfg_we,
    input wire logic [31:0] cfg_wdata,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [7:0]  s_axis_tdata,
    input wire logic        s_axis_tlast,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [7:0]  m_axis_tdata,
    input wire logic        m_axis_tlast,
    input wire logic        m_axis_tuser
);

    logic [31:0] addr_reg;

    // Shadow of the answer address
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg <= '0;
        end else if (cfg_we) begin
            addr_reg <= cfg_wdata;
        end
    end

    // Output empties during reset
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_axis_tvalid)
        else $error("reply valid after reset");

    // Discard only on the final byte of a reply
    a_discard_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("discard mark on a non-final byte");

    // A sent reply ends with the last address octet
    a_record_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tlast && !m_axis_tuser |-> m_axis_tdata == addr_reg[7:0])
        else $error("answer record does not end with the address");

    // A stalled reply byte holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) &&
            $stable(m_axis_tuser))
        else $error("stalled reply changed");

endmodule

bind captive_dns_responder_core cdns_checker u_cdns_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
